FILE: design/gamepad_report_conditioner_core_macros.svh
// Assertion macros shared by the gamepad report conditioner RTL
`ifndef GAMEPAD_REPORT_CONDITIONER_CORE_MACROS_SVH
`define GAMEPAD_REPORT_CONDITIONER_CORE_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define GPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gpc assertion failed");

// Check that a condition is followed in the next cycle by a result
`define GPC_ASSERT_NEXT(name, clk, rst_n, cond, nxt) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("gpc sequence assertion failed");

`endif

FILE: design/gpc_pkg.sv
// Types and constants shared by the gamepad report conditioner
`default_nettype none

package gpc_pkg;

  localparam logic [7:0] CfgIdxPortOpen  = 8'd0;
  localparam logic [7:0] CfgIdxThreshold = 8'd1;
  localparam logic [7:0] CfgIdxDelay     = 8'd2;
  localparam logic [7:0] CfgIdxRate      = 8'd3;

  localparam logic [7:0] AnalogMode = 8'h73;

  localparam logic [1:0] LinkDown   = 2'd0;
  localparam logic [1:0] LinkStable = 2'd1;

  localparam int unsigned DpadUpBit    = 4;
  localparam int unsigned DpadRightBit = 5;
  localparam int unsigned DpadDownBit  = 6;
  localparam int unsigned DpadLeftBit  = 7;

  typedef struct packed {
    logic        port_open;
    logic [14:0] stick_threshold;
    logic [7:0]  repeat_delay;
    logic [7:0]  repeat_rate;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    port_open:       1'b0,
    stick_threshold: 15'd8192,
    repeat_delay:    8'd20,
    repeat_rate:     8'd5
  };

  typedef struct packed {
    logic [3:0] dirs;
    logic [3:0] strobe;
  } dir_result_t;

endpackage

`default_nettype wire

FILE: design/gpc_axis_scale.sv
// Stick byte to signed Q1.14 with dead zone and rescale
`default_nettype none

module gpc_axis_scale
  import gpc_pkg::*;
(
  input  var logic        [7:0]  raw_i,
  output var logic signed [15:0] scaled_o
);

  localparam logic [7:0]  PosStart   = 8'd154;
  localparam logic [7:0]  NegEnd     = 8'd101;
  localparam logic [7:0]  PosBase    = 8'd153;
  localparam logic [7:0]  NegBase    = 8'd102;
  localparam logic [20:0] RoundBias  = 21'd51;
  localparam logic [21:0] ScaleRecip = 22'd2631721;
  localparam int unsigned ScaleShift = 28;

  logic        pos;
  logic        neg;
  logic [7:0]  k_wide;
  logic [20:0] num;
  logic [42:0] prod;
  logic [14:0] mag;

  assign pos    = raw_i >= PosStart;
  assign neg    = raw_i <= NegEnd;
  assign k_wide = pos ? (raw_i - PosBase) : (NegBase - raw_i);
  // magnitude = floor((16384*k + 51) / 102) by reciprocal multiply
  assign num    = {k_wide[6:0], 14'b0} + RoundBias;
  assign prod   = {22'b0, num} * {21'b0, ScaleRecip};
  assign mag    = prod[ScaleShift +: 15];

  always_comb begin
    priority if (pos) begin
      scaled_o = $signed({1'b0, mag});
    end else if (neg) begin
      scaled_o = -$signed({1'b0, mag});
    end else begin
      scaled_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: design/gpc_dir_repeat.sv
// Direction decode and auto-repeat state
`default_nettype none

module gpc_dir_repeat
  import gpc_pkg::*;
(
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               advance_i,
  input  var logic        [15:0] buttons_i,
  input  var logic signed [15:0] left_x_i,
  input  var logic signed [15:0] left_y_i,
  input  var cfg_t               cfg_i,
  output var dir_result_t        result_o
);

  logic [3:0] last_dirs_q, last_dirs_d;
  logic [7:0] repeat_cnt_q, repeat_cnt_d;

  logic signed [16:0] lx_ext;
  logic signed [16:0] ly_ext;
  logic signed [16:0] thr_ext;
  logic [3:0]         dirs;
  logic [3:0]         fresh;

  assign lx_ext  = {left_x_i[15], left_x_i};
  assign ly_ext  = {left_y_i[15], left_y_i};
  assign thr_ext = $signed({2'b0, cfg_i.stick_threshold});

  assign dirs[0] = buttons_i[DpadUpBit]    | (ly_ext < -thr_ext);
  assign dirs[1] = buttons_i[DpadDownBit]  | (ly_ext > thr_ext);
  assign dirs[2] = buttons_i[DpadLeftBit]  | (lx_ext < -thr_ext);
  assign dirs[3] = buttons_i[DpadRightBit] | (lx_ext > thr_ext);

  assign fresh       = dirs & ~last_dirs_q;
  assign last_dirs_d = dirs;

  always_comb begin
    result_o.dirs   = dirs;
    result_o.strobe = fresh;
    priority if (fresh != 4'b0 || dirs == 4'b0) begin
      repeat_cnt_d = cfg_i.repeat_delay;
    end else if (repeat_cnt_q <= 8'd1) begin
      repeat_cnt_d    = cfg_i.repeat_rate;
      result_o.strobe = dirs;
    end else begin
      repeat_cnt_d = repeat_cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dirs_q  <= '0;
      repeat_cnt_q <= '0;
    end else if (advance_i) begin
      last_dirs_q  <= last_dirs_d;
      repeat_cnt_q <= repeat_cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/gamepad_report_conditioner_core.sv
// Gamepad report conditioner: input register, frame logic, result register
// A report passes through the input register and then the result register.
// Throughput: one report per cycle while the output is not stalled; input
// register moves into the result register when that is empty or draining.
// Reset: clears valids, edge history, repeat counter and analog request flag;
// configuration returns to port closed, threshold 0.5, delay 20, rate 5.
`default_nettype none

`include "gamepad_report_conditioner_core_macros.svh"

module gamepad_report_conditioner_core
  import gpc_pkg::*;
(
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               cfg_valid_i,
  output var logic               cfg_ready_o,
  input  var logic        [7:0]  cfg_index_i,
  input  var logic        [15:0] cfg_data_i,
  input  var logic               in_valid_i,
  output var logic               in_stall_o,
  input  var logic        [1:0]  link_state_i,
  input  var logic               read_ok_i,
  input  var logic        [7:0]  mode_id_i,
  input  var logic        [7:0]  button_high_i,
  input  var logic        [7:0]  button_low_i,
  input  var logic        [7:0]  right_stick_x_i,
  input  var logic        [7:0]  right_stick_y_i,
  input  var logic        [7:0]  left_stick_x_i,
  input  var logic        [7:0]  left_stick_y_i,
  output var logic               out_valid_o,
  input  var logic               out_stall_i,
  output var logic               connected_o,
  output var logic        [15:0] buttons_o,
  output var logic        [15:0] pressed_o,
  output var logic        [15:0] released_o,
  output var logic        [3:0]  directions_o,
  output var logic        [3:0]  direction_strobe_o,
  output var logic signed [15:0] left_x_scaled_o,
  output var logic signed [15:0] left_y_scaled_o,
  output var logic signed [15:0] right_x_scaled_o,
  output var logic signed [15:0] right_y_scaled_o,
  output var logic               request_analog_o
);

  cfg_t cfg_q;

  logic       in_valid_q;
  logic [1:0] link_q;
  logic       read_ok_q;
  logic [7:0] mode_q;
  logic [7:0] btn_hi_q;
  logic [7:0] btn_lo_q;
  logic [7:0] rx_raw_q;
  logic [7:0] ry_raw_q;
  logic [7:0] lx_raw_q;
  logic [7:0] ly_raw_q;

  logic        out_valid_q;
  logic        connected_q;
  logic [15:0] buttons_q;
  logic [15:0] pressed_q;
  logic [15:0] released_q;
  logic [3:0]  dirs_q;
  logic [3:0]  strobe_q;
  logic signed [15:0] lx_q, ly_q, rx_q, ry_q;
  logic        req_q;

  logic [15:0] last_buttons_q, last_buttons_d;
  logic        analog_req_q, analog_req_d;

  logic advance;
  logic in_accept;

  logic               conn;
  logic               analog;
  logic [15:0]        btns;
  logic               req;
  logic               req_flag_mid;
  logic signed [15:0] rx_s, ry_s, lx_s, ly_s;
  logic signed [15:0] rx_v, ry_v, lx_v, ly_v;
  dir_result_t        dir_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgIdxPortOpen:  cfg_q.port_open       <= cfg_data_i[0];
        CfgIdxThreshold: cfg_q.stick_threshold <= cfg_data_i[14:0];
        CfgIdxDelay:     cfg_q.repeat_delay    <= cfg_data_i[7:0];
        CfgIdxRate:      cfg_q.repeat_rate     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      link_q    <= link_state_i;
      read_ok_q <= read_ok_i;
      mode_q    <= mode_id_i;
      btn_hi_q  <= button_high_i;
      btn_lo_q  <= button_low_i;
      rx_raw_q  <= right_stick_x_i;
      ry_raw_q  <= right_stick_y_i;
      lx_raw_q  <= left_stick_x_i;
      ly_raw_q  <= left_stick_y_i;
    end
  end

  assign conn   = cfg_q.port_open && read_ok_q;
  assign analog = conn && (mode_q == AnalogMode);
  assign btns   = conn ? ~{btn_hi_q, btn_lo_q} : 16'h0000;

  // disconnect rearms the one-shot analog request
  assign req_flag_mid = (link_q == LinkDown) ? 1'b0 : analog_req_q;
  assign req          = cfg_q.port_open && !req_flag_mid && (link_q == LinkStable);

  always_comb begin
    analog_req_d = analog_req_q;
    if (cfg_q.port_open) begin
      analog_req_d = req_flag_mid || req;
    end
  end

  assign last_buttons_d = btns;

  gpc_axis_scale u_scale_rx (.raw_i(rx_raw_q), .scaled_o(rx_s));
  gpc_axis_scale u_scale_ry (.raw_i(ry_raw_q), .scaled_o(ry_s));
  gpc_axis_scale u_scale_lx (.raw_i(lx_raw_q), .scaled_o(lx_s));
  gpc_axis_scale u_scale_ly (.raw_i(ly_raw_q), .scaled_o(ly_s));

  assign rx_v = analog ? rx_s : 16'sd0;
  assign ry_v = analog ? ry_s : 16'sd0;
  assign lx_v = analog ? lx_s : 16'sd0;
  assign ly_v = analog ? ly_s : 16'sd0;

  gpc_dir_repeat u_dir_repeat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .buttons_i (btns),
    .left_x_i  (lx_v),
    .left_y_i  (ly_v),
    .cfg_i     (cfg_q),
    .result_o  (dir_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_buttons_q <= '0;
      analog_req_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (advance) begin
        last_buttons_q <= last_buttons_d;
        analog_req_q   <= analog_req_d;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      connected_q <= conn;
      buttons_q   <= btns;
      pressed_q   <= btns & ~last_buttons_q;
      released_q  <= last_buttons_q & ~btns;
      dirs_q      <= dir_res.dirs;
      strobe_q    <= dir_res.strobe;
      lx_q        <= lx_v;
      ly_q        <= ly_v;
      rx_q        <= rx_v;
      ry_q        <= ry_v;
      req_q       <= req;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign connected_o        = connected_q;
  assign buttons_o          = buttons_q;
  assign pressed_o          = pressed_q;
  assign released_o         = released_q;
  assign directions_o       = dirs_q;
  assign direction_strobe_o = strobe_q;
  assign left_x_scaled_o    = lx_q;
  assign left_y_scaled_o    = ly_q;
  assign right_x_scaled_o   = rx_q;
  assign right_y_scaled_o   = ry_q;
  assign request_analog_o   = req_q;

  `GPC_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !in_stall_o || in_valid_q)
  `GPC_ASSERT_NEXT(a_advance_loads_result, clk_i, rst_ni, advance, out_valid_q)
  `GPC_ASSERT(a_edges_disjoint, clk_i, rst_ni, !out_valid_q || ((pressed_q & released_q) == 16'h0000))
  `GPC_ASSERT(a_strobe_within_held, clk_i, rst_ni, !out_valid_q || ((strobe_q & ~dirs_q) == 4'h0))
  `GPC_ASSERT(a_idle_frame_quiet, clk_i, rst_ni, !out_valid_q || connected_q || (buttons_q == 16'h0000 && lx_q == 16'sd0 && ry_q == 16'sd0))

endmodule

`default_nettype wire
